// ----- sv/usart_pkg.sv -----
`default_nettype none

package usart_pkg;

   // Default width of the bit period register
   localparam int PERIOD_BITS_DEF = 24;

   // Transmit busy countdown
   localparam int TX_COUNT_BITS = 28;
   localparam logic [TX_COUNT_BITS-1:0] TX_COUNT_MAX = {TX_COUNT_BITS{1'b1}};

   // Stream widths
   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 1;

   // Request action codes (5..7 do nothing)
   localparam logic [2:0] ACT_TICK        = 3'd0;
   localparam logic [2:0] ACT_READ_STATUS = 3'd1;
   localparam logic [2:0] ACT_READ_DATA   = 3'd2;
   localparam logic [2:0] ACT_WRITE_DATA  = 3'd3;
   localparam logic [2:0] ACT_WRITE_CTRL  = 3'd4;

   // Configuration register indexes
   localparam logic CSR_BIT_PERIOD  = 1'b0;
   localparam logic CSR_DSR_FOLLOWS = 1'b1;

   // Command word bit positions
   localparam int CMD_DTR    = 1;
   localparam int CMD_RX_EN  = 2;
   localparam int CMD_BREAK  = 3;
   localparam int CMD_RTS    = 5;
   localparam int CMD_IRESET = 6;

   // Status byte bit positions
   localparam int STAT_TXRDY   = 0;
   localparam int STAT_RXRDY   = 1;
   localparam int STAT_TXEMPTY = 2;
   localparam int STAT_DSR     = 7;

   // Mode word after reset
   localparam logic [7:0] MODE_RESET = 8'h4E;

   // Parity codes
   localparam logic [1:0] PARITY_NONE = 2'd0;
   localparam logic [1:0] PARITY_ODD  = 2'd1;
   localparam logic [1:0] PARITY_EVEN = 2'd2;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] write_value;
      logic       line_byte_valid;
      logic [7:0] line_byte;
      logic       far_end_writable;
   } req_item_type;

   typedef struct packed {
      logic [7:0] read_value;
      logic       line_byte_taken;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       rts_asserted;
      logic       dtr_asserted;
      logic       send_break;
      logic [3:0] data_bits;
      logic [1:0] parity_mode;
      logic [1:0] stop_bits;
   } rsp_item_type;

   function automatic logic [3:0] mode_data_bits(input logic [7:0] mode);
      mode_data_bits = 4'd5 + {2'b00, mode[3:2]};
   endfunction

   function automatic logic [1:0] mode_parity(input logic [7:0] mode);
      if (!mode[4]) begin
         mode_parity = PARITY_NONE;
      end else if (mode[5]) begin
         mode_parity = PARITY_EVEN;
      end else begin
         mode_parity = PARITY_ODD;
      end
   endfunction

   // 1.5 stop bits counts as 2
   function automatic logic [1:0] mode_stop_bits(input logic [7:0] mode);
      mode_stop_bits = mode[7] ? 2'd2 : 2'd1;
   endfunction

   // start + data + parity + stop, at most 12
   function automatic logic [3:0] bits_per_char(input logic [7:0] mode);
      logic par;
      par = (mode_parity(mode) != PARITY_NONE);
      bits_per_char = 4'd1 + mode_data_bits(mode) + {3'b000, par}
                      + {2'b00, mode_stop_bits(mode)};
   endfunction

   // mask of the data bits of a character
   function automatic logic [7:0] data_mask(input logic [7:0] mode);
      unique case (mode[3:2])
         2'd0:    data_mask = 8'h1F;
         2'd1:    data_mask = 8'h3F;
         2'd2:    data_mask = 8'h7F;
         default: data_mask = 8'hFF;
      endcase
   endfunction

endpackage

`default_nettype wire

// ----- sv/usart_core.sv -----
`default_nettype none

module usart_core
   import usart_pkg::*;
#(
   parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // configuration writes
   input  wire logic                   csr_we,
   input  wire logic                   csr_index,
   input  wire logic [PERIOD_BITS-1:0] csr_data,
   // one request per asserted step
   input  wire logic                   step_fire,
   input  wire req_item_type           step_req,
   output      rsp_item_type           step_rsp
);

   localparam int PROD_W = (PERIOD_BITS + 4 > TX_COUNT_BITS) ? PERIOD_BITS + 4 : TX_COUNT_BITS;

   // configuration
   logic [PERIOD_BITS-1:0] bit_period_ff;
   logic                   dsr_follows_ff;

   // USART state
   logic                     expect_mode_ff, expect_mode_in;
   logic [7:0]               mode_word_ff, mode_word_in;
   logic [7:0]               command_word_ff, command_word_in;
   logic [7:0]               rx_holding_ff, rx_holding_in;
   logic                     rx_ready_ff, rx_ready_in;
   logic [7:0]               rx_shift_ff, rx_shift_in;
   logic                     rx_active_ff, rx_active_in;
   logic [PERIOD_BITS-1:0]   rx_bit_phase_ff, rx_bit_phase_in;
   logic [3:0]               rx_bit_index_ff, rx_bit_index_in;
   logic [TX_COUNT_BITS-1:0] tx_busy_count_ff, tx_busy_count_in;

   logic                     period_zero;
   logic [3:0]               nd_cur;
   logic [3:0]               idx_m1;
   logic                     data_xor;
   logic                     dsr_bit;
   logic [7:0]               status_byte;
   logic [PROD_W-1:0]        tx_product;
   logic [TX_COUNT_BITS-1:0] tx_load;
   logic [PERIOD_BITS:0]     phase_sum;
   logic [7:0]               read_value;
   logic                     line_taken;
   logic                     tx_valid;
   logic [7:0]               tx_byte;

   assign period_zero = (bit_period_ff == '0);
   assign nd_cur      = mode_data_bits(mode_word_ff);
   assign idx_m1      = rx_bit_index_ff - 4'd1;
   assign data_xor    = ^(rx_shift_ff & data_mask(mode_word_ff));

   // Status bit 7: inverted receive waveform of the frame in flight
   always_comb begin
      priority if (!dsr_follows_ff || !rx_active_ff || period_zero) begin
         dsr_bit = 1'b0;
      end else if (rx_bit_index_ff == 4'd0) begin
         dsr_bit = 1'b1;
      end else if (rx_bit_index_ff <= nd_cur) begin
         dsr_bit = ~rx_shift_ff[idx_m1[2:0]];
      end else if ((mode_parity(mode_word_ff) != PARITY_NONE)
                   && (rx_bit_index_ff == nd_cur + 4'd1)) begin
         // inverted parity bit: even parity sends the data xor
         dsr_bit = (mode_parity(mode_word_ff) == PARITY_EVEN) ? ~data_xor : data_xor;
      end else begin
         dsr_bit = 1'b0;
      end
   end

   always_comb begin
      status_byte               = 8'h00;
      status_byte[STAT_TXRDY]   = (tx_busy_count_ff == '0) && step_req.far_end_writable;
      status_byte[STAT_RXRDY]   = rx_ready_ff;
      status_byte[STAT_TXEMPTY] = (tx_busy_count_ff == '0);
      status_byte[STAT_DSR]     = dsr_bit;
   end

   // Transmit busy time: one frame of bit periods, saturating
   assign tx_product = PROD_W'(bit_period_ff) * PROD_W'(bits_per_char(mode_word_ff));
   assign tx_load    = (tx_product > PROD_W'(TX_COUNT_MAX)) ? TX_COUNT_MAX
                                                            : tx_product[TX_COUNT_BITS-1:0];

   assign phase_sum = {1'b0, rx_bit_phase_ff} + {{PERIOD_BITS{1'b0}}, 1'b1};

   // Action, then receiver poll
   always_comb begin
      expect_mode_in   = expect_mode_ff;
      mode_word_in     = mode_word_ff;
      command_word_in  = command_word_ff;
      rx_holding_in    = rx_holding_ff;
      rx_ready_in      = rx_ready_ff;
      rx_shift_in      = rx_shift_ff;
      rx_active_in     = rx_active_ff;
      rx_bit_phase_in  = rx_bit_phase_ff;
      rx_bit_index_in  = rx_bit_index_ff;
      tx_busy_count_in = tx_busy_count_ff;
      read_value       = 8'h00;
      line_taken       = 1'b0;
      tx_valid         = 1'b0;
      tx_byte          = 8'h00;

      unique case (step_req.action)
         ACT_TICK: begin
            if (tx_busy_count_ff != '0) begin
               tx_busy_count_in = tx_busy_count_ff - {{(TX_COUNT_BITS-1){1'b0}}, 1'b1};
            end
            if (rx_active_ff && !period_zero) begin
               if (phase_sum >= {1'b0, bit_period_ff}) begin
                  rx_bit_phase_in = '0;
                  if (rx_bit_index_ff != 4'd15) begin
                     rx_bit_index_in = rx_bit_index_ff + 4'd1;
                  end
               end else begin
                  rx_bit_phase_in = phase_sum[PERIOD_BITS-1:0];
               end
            end
         end
         ACT_READ_STATUS: begin
            read_value = status_byte;
         end
         ACT_READ_DATA: begin
            rx_ready_in = 1'b0;
            read_value  = rx_holding_ff;
         end
         ACT_WRITE_DATA: begin
            tx_valid         = 1'b1;
            tx_byte          = step_req.write_value;
            tx_busy_count_in = tx_load;
         end
         ACT_WRITE_CTRL: begin
            if (expect_mode_ff) begin
               mode_word_in   = step_req.write_value;
               expect_mode_in = 1'b0;
            end else begin
               command_word_in = step_req.write_value;
               if (step_req.write_value[CMD_IRESET]) begin
                  expect_mode_in = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      // frame complete
      if (rx_active_in && (period_zero || (rx_bit_index_in >= bits_per_char(mode_word_in))))
      begin
         rx_holding_in = rx_shift_in;
         rx_ready_in   = 1'b1;
         rx_active_in  = 1'b0;
      end
      // start a new frame from the line
      if (!rx_active_in && !rx_ready_in && command_word_in[CMD_RX_EN]
          && step_req.line_byte_valid) begin
         rx_shift_in     = step_req.line_byte;
         rx_bit_phase_in = '0;
         rx_bit_index_in = 4'd0;
         rx_active_in    = 1'b1;
         line_taken      = 1'b1;
      end
   end

   always_comb begin
      step_rsp.read_value      = read_value;
      step_rsp.line_byte_taken = line_taken;
      step_rsp.tx_valid        = tx_valid;
      step_rsp.tx_byte         = tx_byte;
      step_rsp.rts_asserted    = command_word_in[CMD_RTS];
      step_rsp.dtr_asserted    = command_word_in[CMD_DTR];
      step_rsp.send_break      = command_word_in[CMD_BREAK];
      step_rsp.data_bits       = mode_data_bits(mode_word_in);
      step_rsp.parity_mode     = mode_parity(mode_word_in);
      step_rsp.stop_bits       = mode_stop_bits(mode_word_in);
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff  <= '0;
         dsr_follows_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BIT_PERIOD:  bit_period_ff  <= csr_data;
            CSR_DSR_FOLLOWS: dsr_follows_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         expect_mode_ff   <= 1'b1;
         mode_word_ff     <= MODE_RESET;
         command_word_ff  <= 8'h00;
         rx_holding_ff    <= 8'h00;
         rx_ready_ff      <= 1'b0;
         rx_shift_ff      <= 8'h00;
         rx_active_ff     <= 1'b0;
         rx_bit_phase_ff  <= '0;
         rx_bit_index_ff  <= 4'd0;
         tx_busy_count_ff <= '0;
      end else if (step_fire) begin
         expect_mode_ff   <= expect_mode_in;
         mode_word_ff     <= mode_word_in;
         command_word_ff  <= command_word_in;
         rx_holding_ff    <= rx_holding_in;
         rx_ready_ff      <= rx_ready_in;
         rx_shift_ff      <= rx_shift_in;
         rx_active_ff     <= rx_active_in;
         rx_bit_phase_ff  <= rx_bit_phase_in;
         rx_bit_index_ff  <= rx_bit_index_in;
         tx_busy_count_ff <= tx_busy_count_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/usart_rsp_queue.sv -----
`default_nettype none

module usart_rsp_queue
   import usart_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire rsp_item_type push_item,
   output      logic         full,
   output      logic         head_valid,
   output      rsp_item_type head_item,
   input  wire logic         pop_ready
);

   logic         head_valid_ff, head_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type head_ff, head_in;
   rsp_item_type skid_ff, skid_in;
   logic         pop;

   assign pop        = head_valid_ff && pop_ready;
   assign full       = skid_valid_ff;
   assign head_valid = head_valid_ff;
   assign head_item  = head_ff;

   // Two-entry queue: head drives the port, skid catches one more
   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_in = skid_ff;
            if (push) begin
               skid_in = push_item;
            end else begin
               skid_valid_in = 1'b0;
            end
         end else if (push) begin
            head_in = push_item;
         end else begin
            head_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!head_valid_ff) begin
            head_in       = push_item;
            head_valid_in = 1'b1;
         end else begin
            skid_in       = push_item;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

// ----- sv/async_usart_registers.sv -----
// Channel | Handshake             | Payload
// --------+-----------------------+------------------------------------------
// req     | req_tvalid/req_tready | tuser: action, line_byte_valid
//         |                       | tdata: write_value, line_byte, far_end_writable
// rsp     | rsp_tvalid/rsp_tready | tuser: tx_valid; tdata: read_value .. stop_bits
// csr     | csr_valid/csr_ready   | csr_index, csr_data (bit_period, dsr_follows_rxd)
//
// One request per cycle while req_tready is high; a response reaches rsp after its
// request has passed the input register and the single-pass update into the queue.
// Synchronous reset returns the USART to waiting for a mode word, mode 0x4E.
// A two-entry response queue absorbs rsp stalls; req_tready drops only while the
// input register and both queue entries are occupied. csr writes are never stalled.
`default_nettype none

module async_usart_registers
   import usart_pkg::*;
#(
   parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   // [7:0] write_value, [15:8] line_byte, [16] far_end_writable
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   // [2:0] action, [3] line_byte_valid
   input  wire logic [REQ_USER_W-1:0]  req_tuser,
   // response channel
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [7:0] read_value, [8] line_byte_taken, [16:9] tx_byte, [17] rts_asserted,
   // [18] dtr_asserted, [19] send_break, [23:20] data_bits, [25:24] parity_mode,
   // [27:26] stop_bits
   output      logic [RSP_DATA_W-1:0]  rsp_tdata,
   // [0] tx_valid
   output      logic [RSP_USER_W-1:0]  rsp_tuser,
   // configuration write channel
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic                   csr_index,
   input  wire logic [PERIOD_BITS-1:0] csr_data
);

   logic                  in_valid_ff, in_valid_in;
   logic [REQ_DATA_W-1:0] in_data_ff;
   logic [REQ_USER_W-1:0] in_user_ff;
   req_item_type          step_req;
   rsp_item_type          step_rsp;
   rsp_item_type          head_item;
   logic                  q_full;
   logic                  step_fire;
   logic                  req_fire;

   assign csr_ready  = 1'b1;
   assign step_fire  = in_valid_ff && !q_full;
   assign req_tready = !in_valid_ff || !q_full;
   assign req_fire   = req_tvalid && req_tready;

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_tdata;
         in_user_ff <= req_tuser;
      end
   end

   // Unpack the registered request
   always_comb begin
      step_req.action           = in_user_ff[2:0];
      step_req.line_byte_valid  = in_user_ff[3];
      step_req.write_value      = in_data_ff[7:0];
      step_req.line_byte        = in_data_ff[15:8];
      step_req.far_end_writable = in_data_ff[16];
   end

   usart_core #(
      .PERIOD_BITS(PERIOD_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .step_fire (step_fire),
      .step_req  (step_req),
      .step_rsp  (step_rsp)
   );

   usart_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (step_fire),
      .push_item  (step_rsp),
      .full       (q_full),
      .head_valid (rsp_tvalid),
      .head_item  (head_item),
      .pop_ready  (rsp_tready)
   );

   // Pack the response
   always_comb begin
      rsp_tdata        = '0;
      rsp_tdata[7:0]   = head_item.read_value;
      rsp_tdata[8]     = head_item.line_byte_taken;
      rsp_tdata[16:9]  = head_item.tx_byte;
      rsp_tdata[17]    = head_item.rts_asserted;
      rsp_tdata[18]    = head_item.dtr_asserted;
      rsp_tdata[19]    = head_item.send_break;
      rsp_tdata[23:20] = head_item.data_bits;
      rsp_tdata[25:24] = head_item.parity_mode;
      rsp_tdata[27:26] = head_item.stop_bits;
      rsp_tuser[0]     = head_item.tx_valid;
   end

   // Backpressure only comes from a queue that is holding responses
   assert property (@(posedge clock) disable iff (reset) !req_tready |-> rsp_tvalid)
      else $error("req stalled with an empty response queue");

   // No transmitted byte leaks out without tx_valid
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[16:9] == 8'h00))
      else $error("tx_byte nonzero without tx_valid");

   // Decoded mode fields stay in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[23:20] >= 4'd5) && (rsp_tdata[23:20] <= 4'd8)
                      && (rsp_tdata[25:24] != 2'd3) && (rsp_tdata[27:26] != 2'd0)))
      else $error("mode fields out of range");

   // A data write never returns read data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[7:0] == 8'h00))
      else $error("read_value nonzero on a data write");

endmodule

`default_nettype wire

// ----- tb/sv/usart_checker.sv -----
`timescale 1ns / 100ps

// Watches the request, response and register channels of the USART, keeps its own
// copy of the USART state, and compares every response with the predicted one.
module usart_checker
   import usart_pkg::*;
#(
   parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic [REQ_USER_W-1:0]  req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic [RSP_USER_W-1:0]  rsp_tuser,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [PERIOD_BITS-1:0] csr_data,
   input  logic                   run_done,
   output int                     fail_count,
   output int                     checked_count,
   output int                     pending
);

   // register copies
   logic [PERIOD_BITS-1:0] period_q;
   logic                   dsr_mirror;

   // USART state
   logic                     want_mode;
   logic [7:0]               mode_q;
   logic [7:0]               cmd_q;
   logic [7:0]               rx_hold;
   logic                     rx_full;
   logic [7:0]               rx_shift_q;
   logic                     rx_busy;
   logic [31:0]              rx_phase;
   logic [3:0]               rx_bit_idx;
   logic [TX_COUNT_BITS-1:0] tx_left;
   logic                     closed;

   rsp_item_type expected_rsp_q[$];

   function automatic int unsigned char_bits();
      return 5 + int'(mode_q[3:2]);
   endfunction

   function automatic logic [1:0] parity_kind();
      if (!mode_q[4]) return PARITY_NONE;
      return mode_q[5] ? PARITY_EVEN : PARITY_ODD;
   endfunction

   // 1.5 stop bits rounds up to 2
   function automatic int unsigned stop_count();
      return mode_q[7] ? 2 : 1;
   endfunction

   function automatic int unsigned frame_bits();
      return 1 + char_bits() + ((parity_kind() != PARITY_NONE) ? 1 : 0) + stop_count();
   endfunction

   // parity bit that the frame in flight carries
   function automatic logic rx_parity();
      int unsigned mask;
      logic [7:0]  d;
      mask = (1 << char_bits()) - 1;
      d = rx_shift_q & mask[7:0];
      return (parity_kind() == PARITY_EVEN) ? ^d : ~^d;
   endfunction

   // inverted receive line level seen on DSR: start bit, data bits, parity bit
   function automatic logic line_mirror();
      int unsigned nd;
      int unsigned i;
      nd = char_bits();
      i = rx_bit_idx;
      if (!dsr_mirror || !rx_busy || period_q == 0) return 1'b0;
      if (i == 0) return 1'b1;
      if (i <= nd) return ~rx_shift_q[i-1];
      if (parity_kind() != PARITY_NONE && i == nd + 1) return ~rx_parity();
      return 1'b0;
   endfunction

   function automatic logic [7:0] status_byte(input logic far);
      logic [7:0] s;
      s = '0;
      s[STAT_TXRDY]   = (tx_left == 0) && far;
      s[STAT_RXRDY]   = rx_full;
      s[STAT_TXEMPTY] = (tx_left == 0);
      s[STAT_DSR]     = line_mirror();
      return s;
   endfunction

   // one bus action followed by the receiver poll
   function automatic rsp_item_type usart_step(input req_item_type r);
      rsp_item_type o;
      logic [63:0]  busy;
      o = '0;
      case (r.action)
         ACT_TICK: begin
            if (tx_left != 0) tx_left = tx_left - 1'b1;
            if (rx_busy && period_q != 0) begin
               rx_phase = rx_phase + 1;
               if (rx_phase >= 32'(period_q)) begin
                  rx_phase = 0;
                  if (rx_bit_idx < 15) rx_bit_idx = rx_bit_idx + 1'b1;
               end
            end
         end
         ACT_READ_STATUS: o.read_value = status_byte(r.far_end_writable);
         ACT_READ_DATA: begin
            rx_full = 1'b0;
            o.read_value = rx_hold;
         end
         ACT_WRITE_DATA: begin
            busy = 64'(period_q) * 64'(frame_bits());
            tx_left = (busy > 64'(TX_COUNT_MAX)) ? TX_COUNT_MAX : busy[TX_COUNT_BITS-1:0];
            o.tx_valid = 1'b1;
            o.tx_byte  = r.write_value;
         end
         ACT_WRITE_CTRL: begin
            if (want_mode) begin
               mode_q = r.write_value;
               want_mode = 1'b0;
            end else begin
               cmd_q = r.write_value;
               if (r.write_value[CMD_IRESET]) want_mode = 1'b1;
            end
         end
         default: ;
      endcase

      // finished frame moves to the holding register, then a new one may start
      if (rx_busy && (period_q == 0 || rx_bit_idx >= frame_bits())) begin
         rx_hold = rx_shift_q;
         rx_full = 1'b1;
         rx_busy = 1'b0;
      end
      if (!rx_busy && !rx_full && cmd_q[CMD_RX_EN] && r.line_byte_valid) begin
         rx_shift_q = r.line_byte;
         rx_phase   = 0;
         rx_bit_idx = 0;
         rx_busy    = 1'b1;
         o.line_byte_taken = 1'b1;
      end

      o.rts_asserted = cmd_q[CMD_RTS];
      o.dtr_asserted = cmd_q[CMD_DTR];
      o.send_break   = cmd_q[CMD_BREAK];
      o.data_bits    = 4'(char_bits());
      o.parity_mode  = parity_kind();
      o.stop_bits    = 2'(stop_count());
      return o;
   endfunction

   // print is capped so a broken build stays readable; every mismatch counts
   task automatic report_mismatch(input string what);
      if (fail_count < 100) $display("%0t ns mismatch: %s", $time, what);
      fail_count++;
   endtask

   task automatic compare_field(input string name, input int unsigned got,
                                input int unsigned want);
      if (got != want)
         report_mismatch($sformatf("%s is 0x%0h, predicted 0x%0h", name, got, want));
   endtask

   always @(posedge clock) begin : watch
      req_item_type r;
      rsp_item_type got;
      rsp_item_type want;
      rsp_item_type predicted;
      if (reset) begin
         period_q   = '0;
         dsr_mirror = 1'b0;
         want_mode  = 1'b1;
         mode_q     = MODE_RESET;
         cmd_q      = '0;
         rx_hold    = '0;
         rx_full    = 1'b0;
         rx_shift_q = '0;
         rx_busy    = 1'b0;
         rx_phase   = '0;
         rx_bit_idx = '0;
         tx_left    = '0;
         closed     = 1'b0;
         fail_count    = 0;
         checked_count = 0;
         expected_rsp_q.delete();
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_BIT_PERIOD) begin
               period_q = csr_data;
            end else begin
               dsr_mirror = csr_data[0];
            end
         end

         // accepted request: predict its response
         if (req_tvalid && req_tready) begin
            r.action           = req_tuser[2:0];
            r.line_byte_valid  = req_tuser[3];
            r.write_value      = req_tdata[7:0];
            r.line_byte        = req_tdata[15:8];
            r.far_end_writable = req_tdata[16];
            predicted = usart_step(r);
            expected_rsp_q = {expected_rsp_q, predicted};
         end

         // accepted response: compare with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            checked_count++;
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = expected_rsp_q.pop_front();
               got.read_value      = rsp_tdata[7:0];
               got.line_byte_taken = rsp_tdata[8];
               got.tx_byte         = rsp_tdata[16:9];
               got.rts_asserted    = rsp_tdata[17];
               got.dtr_asserted    = rsp_tdata[18];
               got.send_break      = rsp_tdata[19];
               got.data_bits       = rsp_tdata[23:20];
               got.parity_mode     = rsp_tdata[25:24];
               got.stop_bits       = rsp_tdata[27:26];
               got.tx_valid        = rsp_tuser[0];
               compare_field("read_value", got.read_value, want.read_value);
               compare_field("line_byte_taken", got.line_byte_taken, want.line_byte_taken);
               compare_field("tx_valid", got.tx_valid, want.tx_valid);
               compare_field("tx_byte", got.tx_byte, want.tx_byte);
               compare_field("rts_asserted", got.rts_asserted, want.rts_asserted);
               compare_field("dtr_asserted", got.dtr_asserted, want.dtr_asserted);
               compare_field("send_break", got.send_break, want.send_break);
               compare_field("data_bits", got.data_bits, want.data_bits);
               compare_field("parity_mode", got.parity_mode, want.parity_mode);
               compare_field("stop_bits", got.stop_bits, want.stop_bits);
            end
         end

         // end of run: anything still predicted never came out
         if (run_done && !closed) begin
            closed = 1'b1;
            if (expected_rsp_q.size() != 0)
               report_mismatch($sformatf("%0d responses never arrived",
                                         expected_rsp_q.size()));
         end
      end
      pending <= expected_rsp_q.size();
   end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import usart_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 262;
   localparam int PHASE_COUNT = 7;

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [REQ_DATA_W-1:0]      req_tdata;
   logic [REQ_USER_W-1:0]      req_tuser;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]      rsp_tdata;
   logic [RSP_USER_W-1:0]      rsp_tuser;
   logic                       csr_valid;
   logic                       csr_ready;
   logic                       csr_index;
   logic [PERIOD_BITS_DEF-1:0] csr_data;

   logic run_done;
   logic calm;       // no idling on either side
   logic squeeze;    // asks the receiver for one long hold-off
   int   fail_count;
   int   checked_count;
   int   pending;
   int   requests_sent = 0;
   int   cycle_count = 0;
   int   hold_left = 0;
   logic hold_used = 1'b0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   async_usart_registers i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   usart_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .run_done      (run_done),
      .fail_count    (fail_count),
      .checked_count (checked_count),
      .pending       (pending)
   );

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count, pending);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // response side: random stalls, one long hold-off while the sender keeps going
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (squeeze && !hold_used && req_tvalid) begin
         hold_left  <= 150;
         hold_used  <= 1'b1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 31);
      end
   end

   function automatic req_item_type make_req(input logic [2:0] action, input logic [7:0] wv,
                                             input logic lbv, input logic [7:0] lb,
                                             input logic far);
      req_item_type r;
      r.action           = action;
      r.write_value      = wv;
      r.line_byte_valid  = lbv;
      r.line_byte        = lb;
      r.far_end_writable = far;
      return r;
   endfunction

   // mostly ticks and polls; control writes mostly enable receive and avoid
   // the internal reset so frames get through
   function automatic req_item_type random_request();
      req_item_type r;
      int unsigned  pick;
      pick = $urandom_range(99);
      r.write_value      = 8'($urandom_range(255));
      r.line_byte        = 8'($urandom_range(255));
      r.line_byte_valid  = ($urandom_range(99) < 70);
      r.far_end_writable = 1'($urandom_range(1));
      if (pick < 42) begin
         r.action = ACT_TICK;
      end else if (pick < 62) begin
         r.action = ACT_READ_STATUS;
      end else if (pick < 78) begin
         r.action = ACT_READ_DATA;
      end else if (pick < 86) begin
         r.action = ACT_WRITE_DATA;
      end else if (pick < 96) begin
         r.action = ACT_WRITE_CTRL;
         if ($urandom_range(3) != 0) begin
            r.write_value[CMD_IRESET] = 1'b0;
            r.write_value[CMD_RX_EN]  = 1'b1;
         end
      end else begin
         r.action = 3'($urandom_range(7, 5));
      end
      return r;
   endfunction

   // request side: random gaps, then hold the request until it is taken
   task automatic send_request(input req_item_type r);
      while (!calm && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, r.far_end_writable, r.line_byte, r.write_value};
      req_tuser  <= {r.line_byte_valid, r.action};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
   endtask

   // drain: every predicted response back, then let the pipeline empty
   task automatic settle();
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input logic [PERIOD_BITS_DEF-1:0] period, input logic dsr);
      csr_valid <= 1'b1;
      csr_index <= CSR_BIT_PERIOD;
      csr_data  <= period;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_DSR_FOLLOWS;
      csr_data  <= {{(PERIOD_BITS_DEF-1){1'b0}}, dsr};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [PERIOD_BITS_DEF-1:0] period, input logic dsr);
      settle();
      set_config(period, dsr);
      repeat (PHASE_ITEMS) send_request(random_request());
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_BIT_PERIOD;
      csr_data   = '0;
      run_done   = 1'b0;
      calm       = 1'b0;
      squeeze    = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed, with the zero bit period after reset
      send_request(make_req(ACT_READ_STATUS, 8'h00, 1'b1, 8'h3C, 1'b1)); // receive off
      send_request(make_req(ACT_WRITE_CTRL, 8'hFF, 1'b0, 8'h00, 1'b0));  // mode: 8E2
      send_request(make_req(ACT_WRITE_CTRL, 8'h2E, 1'b0, 8'h00, 1'b0));  // RTS, break, RxEN, DTR
      send_request(make_req(ACT_TICK, 8'h00, 1'b1, 8'hFF, 1'b0));        // frame starts
      send_request(make_req(ACT_READ_STATUS, 8'h00, 1'b1, 8'h00, 1'b0)); // frame lands
      send_request(make_req(ACT_READ_STATUS, 8'h00, 1'b0, 8'h00, 1'b1));
      send_request(make_req(ACT_READ_DATA, 8'h00, 1'b1, 8'h00, 1'b1));
      send_request(make_req(ACT_WRITE_DATA, 8'h00, 1'b0, 8'h00, 1'b0));
      send_request(make_req(ACT_WRITE_DATA, 8'hFF, 1'b0, 8'h00, 1'b1));
      send_request(make_req(3'd5, 8'hFF, 1'b1, 8'h81, 1'b1));            // unused codes
      send_request(make_req(3'd6, 8'h00, 1'b1, 8'h81, 1'b0));
      send_request(make_req(3'd7, 8'hFF, 1'b1, 8'h81, 1'b1));
      send_request(make_req(ACT_READ_DATA, 8'h00, 1'b0, 8'h00, 1'b0));
      send_request(make_req(ACT_WRITE_CTRL, 8'h40, 1'b0, 8'h00, 1'b0));  // internal reset
      send_request(make_req(ACT_WRITE_CTRL, 8'h00, 1'b0, 8'h00, 1'b0));  // mode: 5N, stop code 0
      send_request(make_req(ACT_WRITE_CTRL, 8'h04, 1'b0, 8'h00, 1'b0));
      send_request(make_req(ACT_TICK, 8'h00, 1'b1, 8'hA5, 1'b0));
      send_request(make_req(ACT_READ_STATUS, 8'h00, 1'b0, 8'h00, 1'b1));
      send_request(make_req(ACT_READ_DATA, 8'h00, 1'b0, 8'h00, 1'b0));
      send_request(make_req(ACT_WRITE_CTRL, 8'h7F, 1'b0, 8'h00, 1'b0));  // reset with pins
      send_request(make_req(ACT_WRITE_CTRL, 8'h9C, 1'b0, 8'h00, 1'b0));  // mode: 8O2
      send_request(make_req(ACT_WRITE_CTRL, 8'h00, 1'b1, 8'h11, 1'b0));  // everything off
      send_request(make_req(ACT_WRITE_DATA, 8'h5A, 1'b0, 8'h00, 1'b0));  // sent anyway

      // random phases over several register settings
      run_phase(24'd0, 1'b0);
      squeeze <= 1'b1;
      run_phase(24'd1, 1'b1);
      squeeze <= 1'b0;
      calm <= 1'b1;
      run_phase(24'd2, 1'b1);
      calm <= 1'b0;
      run_phase(24'hFFFFFF, 1'b1);
      run_phase(24'd3, 1'b0);
      run_phase(24'd1, 1'b0);
      run_phase(24'd0, 1'b1);

      settle();
      run_done <= 1'b1;
      repeat (3) @(posedge clock);

      $display("%0d requests sent over %0d register settings, %0d responses compared",
               requests_sent, PHASE_COUNT + 1, checked_count);
      $display("bit periods from zero to full scale, DSR mirror on and off, one long stall");
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
